[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the escape rewriter modules.
// Each macro expects clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[sv/jutf_pkg.sv]
// ---------------------------------------------------------------------------
// jutf_pkg
// Types, constants and helpers for the \u00XX escape to UTF-8 rewriter.
// ---------------------------------------------------------------------------
package jutf_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       chunk_done;
  } out_beat_t;

  // One input byte's worth of output: held flush, middle bytes, end-of-chunk flush
  typedef struct packed {
    logic [2:0] head_len;
    logic [1:0] mid_len;
    logic [7:0] mid0;
    logic [7:0] mid1;
    logic [2:0] tail_len;
    logic [7:0] held_h;
    logic       chunk_end;
    logic [2:0] total;
  } job_t;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Held escape bytes in order: backslash, u, 0, 0, H
  function automatic logic [7:0] held_byte(input logic [2:0] pos, input logic [7:0] h);
    logic [7:0] r;
    unique case (pos)
      3'd0:    r = CH_BSLASH;
      3'd1:    r = CH_U;
      3'd2:    r = CH_ZERO;
      3'd3:    r = CH_ZERO;
      default: r = h;
    endcase
    return r;
  endfunction

endpackage

[sv/json_u00_escape_to_utf8.sv]
// Rewrites each \u00XX JSON escape (X high digit 8..F, either case) into its
// two-byte UTF-8 form and passes every other byte through. One output beat is
// produced per cycle from the back part's output register while out_ready
// allows it, so ordinary bytes stream at one per cycle; an input byte whose
// job holds k bytes occupies the output for k beats (up to six), during
// which the front keeps taking input until the job queue (QueueDepth entries)
// fills. An accepted byte's job is registered in the queue, then loaded into
// the output register. A chunk end flushes any partial escape unchanged;
// run_last marks the final beat of each input byte and chunk_done that of a
// chunk-ending byte. Bytes that are merely held produce no beat.
// ---------------------------------------------------------------------------
// json_u00_escape_to_utf8
// Top level: front classifier, job queue and byte-serial back part.
// ---------------------------------------------------------------------------
module json_u00_escape_to_utf8 #(
  parameter int QueueDepth = jutf_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jutf_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jutf_pkg::out_beat_t out_data
);
  import jutf_pkg::*;

  logic q_full, push, pop, head_valid;
  job_t push_job, head_job;

  jutf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  jutf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  jutf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[sv/jutf_front.sv]
// ---------------------------------------------------------------------------
// jutf_front
// Tracks the escape match and turns each input beat into at most one output job.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jutf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  jutf_pkg::in_beat_t in_data,
  input  logic              q_full,
  output logic              push,
  output jutf_pkg::job_t    job
);
  import jutf_pkg::*;

  localparam logic [2:0] PH_NONE = 3'd0;
  localparam logic [2:0] PH_BS   = 3'd1;
  localparam logic [2:0] PH_U    = 3'd2;
  localparam logic [2:0] PH_U0   = 3'd3;
  localparam logic [2:0] PH_U00  = 3'd4;
  localparam logic [2:0] PH_HI   = 3'd5;

  logic [2:0] phase, phase_next;
  logic [7:0] hbyte, hbyte_next;

  logic [7:0] b;
  logic [4:0] hv, hv_hi;
  logic       matched;
  logic [2:0] ph_pre;
  logic [7:0] cp;
  logic       take;

  assign b        = in_data.in_byte;
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    hv    = hex_decode(b);
    hv_hi = hex_decode(hbyte);
    cp    = {hv_hi[3:0], hv[3:0]};

    unique case (phase)
      PH_BS:         matched = (b == CH_U);
      PH_U, PH_U0:   matched = (b == CH_ZERO);
      PH_U00:        matched = hv[4] && hv[3];
      PH_HI:         matched = hv[4];
      default:       matched = 1'b0;
    endcase

    job = '0;
    job.chunk_end = in_data.chunk_end;
    if (!matched && phase >= PH_BS && phase <= PH_HI) begin
      job.head_len = phase;
    end

    if (matched) begin
      if (phase == PH_HI) begin
        job.mid_len = 2'd2;
        job.mid0    = {6'b110000, cp[7:6]};
        job.mid1    = {2'b10, cp[5:0]};
        ph_pre      = PH_NONE;
      end else begin
        ph_pre = phase + 3'd1;
      end
    end else if (b == CH_BSLASH) begin
      ph_pre = PH_BS;
    end else begin
      job.mid_len = 2'd1;
      job.mid0    = b;
      ph_pre      = PH_NONE;
    end

    job.tail_len = in_data.chunk_end ? ph_pre : PH_NONE;
    phase_next   = in_data.chunk_end ? PH_NONE : ph_pre;
    // tail flush of H only happens when this beat is H, head flush uses the stored H
    job.held_h   = (ph_pre == PH_HI) ? b : hbyte;
    job.total    = job.head_len + {1'b0, job.mid_len} + job.tail_len;
    hbyte_next   = (matched && phase == PH_U00) ? b : hbyte;
  end

  assign push = take && (job.total != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NONE;
      hbyte <= 8'h00;
    end else if (take) begin
      phase <= phase_next;
      hbyte <= hbyte_next;
    end
  end

  `ASSERT_NEVER(a_phase_range, phase > PH_HI, "front: phase out of range")
  `ASSERT_ALWAYS(a_job_bound, !(take && job.total > 3'd6), "front: job longer than six bytes")

endmodule

[sv/jutf_queue.sv]
// ---------------------------------------------------------------------------
// jutf_queue
// Short job queue between the front and back parts.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jutf_queue #(
  parameter int Depth = jutf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jutf_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output jutf_pkg::job_t head_job
);
  import jutf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full, "queue: push while full")
  `ASSERT_NEVER(a_no_underflow, pop && !head_valid, "queue: pop while empty")

endmodule

[sv/jutf_back.sv]
// ---------------------------------------------------------------------------
// jutf_back
// Walks each queued job one byte a beat into the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jutf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  jutf_pkg::job_t     head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output jutf_pkg::out_beat_t out_data
);
  import jutf_pkg::*;

  logic [2:0] idx, idx_next;
  logic [2:0] mid_end, rel;
  logic [7:0] cur_byte;
  logic       last;
  logic       load;

  assign load = head_valid && (!out_valid || out_ready);
  assign last = (idx == head_job.total - 3'd1);
  assign pop  = load && last;

  always_comb begin
    mid_end = head_job.head_len + {1'b0, head_job.mid_len};
    rel     = 3'd0;
    if (idx < head_job.head_len) begin
      cur_byte = held_byte(idx, head_job.held_h);
    end else if (idx < mid_end) begin
      rel      = idx - head_job.head_len;
      cur_byte = (rel == 3'd0) ? head_job.mid0 : head_job.mid1;
    end else begin
      rel      = idx - mid_end;
      cur_byte = held_byte(rel, head_job.held_h);
    end
    idx_next = last ? 3'd0 : idx + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte   <= cur_byte;
      out_data.run_last   <= last;
      out_data.chunk_done <= last && head_job.chunk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= idx_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_ALWAYS(a_job_nonempty, !head_valid || head_job.total != 3'd0,
                 "back: empty job in queue")
  `ASSERT_ALWAYS(a_idx_in_job, !head_valid || idx < head_job.total,
                 "back: byte index past end of job")

endmodule

[tb/sv/tb_json_u00_escape_to_utf8.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_json_u00_escape_to_utf8
// Self-checking bench for the \u00XX escape to UTF-8 rewriter. A directed
// stream covers whole escapes, mismatches at each digit and chunk flushes.
// Random escapes, broken escapes and noise bytes follow. Both sides stall at
// random. Every output beat is checked against an in-bench escape matcher.
// ---------------------------------------------------------------------------
module tb_json_u00_escape_to_utf8;
  import jutf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 280;
  localparam int DRAIN_CYCLES = 20;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  json_u00_escape_to_utf8 i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  in_beat_t   text_q[$];   // bytes still to be sent
  out_beat_t  utf8_q[$];   // rewritten beats still to arrive
  logic [7:0] step_bytes[$];
  out_beat_t  utf8_want;

  // matcher state: number of escape bytes held, and the held high digit
  logic [2:0] esc_phase = 3'd0;
  logic [7:0] esc_high  = 8'd0;

  int text_total   = 0;
  int bytes_taken  = 0;
  int cycle_count  = 0;
  int calm_left    = 100;
  int in_gap       = 0;
  int ready_wait   = 0;
  bit calm         = 1'b0;
  bit in_taken     = 1'b0;
  bit mismatch_seen = 1'b0;

  initial forever #4 clk = ~clk;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) return 8'("0" + v);
    if (upper) return 8'("A" + v - 10);
    return 8'("a" + v - 10);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // emit the held part of an escape unchanged and drop the match
  function automatic void release_held();
    if (esc_phase <= 3'd5) begin
      for (int i = 0; i < 4; i++) begin
        if (i < esc_phase)
          step_bytes.push_back(i == 0 ? CH_BSLASH : (i == 1 ? CH_U : CH_ZERO));
      end
      if (esc_phase == 3'd5) step_bytes.push_back(esc_high);
    end
    esc_phase = 3'd0;
  endfunction

  function automatic void take_fresh(input logic [7:0] b);
    if (b == CH_BSLASH) esc_phase = 3'd1;
    else step_bytes.push_back(b);
  endfunction

  function automatic void rewrite_byte(input in_beat_t beat);
    logic [7:0] b;
    logic [7:0] cp;
    int hv;
    out_beat_t res;
    b  = beat.in_byte;
    hv = hex_val(b);
    step_bytes.delete();
    case (esc_phase)
      3'd1: begin
        if (b == CH_U) esc_phase = 3'd2;
        else begin
          release_held();
          take_fresh(b);
        end
      end
      3'd2, 3'd3: begin
        if (b == CH_ZERO) esc_phase = esc_phase + 3'd1;
        else begin
          release_held();
          take_fresh(b);
        end
      end
      3'd4: begin
        if (hv >= 8) begin
          esc_high  = b;
          esc_phase = 3'd5;
        end else begin
          release_held();
          take_fresh(b);
        end
      end
      3'd5: begin
        if (hv >= 0) begin
          cp = 8'(((hex_val(esc_high) & 15) << 4) | hv);
          step_bytes.push_back(8'hC0 | (cp >> 6));
          step_bytes.push_back(8'h80 | (cp & 8'h3F));
          esc_phase = 3'd0;
        end else begin
          release_held();
          take_fresh(b);
        end
      end
      default: begin
        esc_phase = 3'd0;
        take_fresh(b);
      end
    endcase
    if (beat.chunk_end) release_held();
    foreach (step_bytes[i]) begin
      res.out_byte   = step_bytes[i];
      res.run_last   = (i == step_bytes.size() - 1);
      res.chunk_done = res.run_last && beat.chunk_end;
      utf8_q.push_back(res);
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit end_chunk);
    in_beat_t beat;
    beat.in_byte   = b;
    beat.chunk_end = end_chunk;
    text_q.push_back(beat);
  endtask

  task automatic push_text(input string s, input bit end_chunk);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], end_chunk && (i == s.len() - 1));
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0 || text_q.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end else begin
          in_data  <= text_q.pop_front();
          in_valid <= 1'b1;
          in_gap   <= pick_gap();
        end
      end
      if (ready_wait > 0) begin
        out_ready  <= 1'b0;
        ready_wait <= ready_wait - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(3) == 0) ready_wait <= pick_gap();
      end
    end
  end

  // monitor: predict on each accepted byte, check each output beat
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (in_valid && in_ready) begin
        rewrite_byte(in_data);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (utf8_q.size() == 0) begin
          $error("unexpected beat: out_byte %h", out_data.out_byte);
          mismatch_seen = 1'b1;
        end else begin
          utf8_want = utf8_q.pop_front();
          if (out_data.out_byte !== utf8_want.out_byte) begin
            $error("out_byte: expected %h, got %h", utf8_want.out_byte, out_data.out_byte);
            mismatch_seen = 1'b1;
          end
          if (out_data.run_last !== utf8_want.run_last) begin
            $error("run_last: expected %b, got %b", utf8_want.run_last, out_data.run_last);
            mismatch_seen = 1'b1;
          end
          if (out_data.chunk_done !== utf8_want.chunk_done) begin
            $error("chunk_done: expected %b, got %b",
                   utf8_want.chunk_done, out_data.chunk_done);
            mismatch_seen = 1'b1;
          end
        end
      end
    end
  end

  // watchdog; also switches between stalling and stall-free stretches
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (calm_left == 0) begin
      calm      <= !calm;
      calm_left <= $urandom_range(40, 200);
    end else begin
      calm_left <= calm_left - 1;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] esc [6];
    int kind;
    int cut;
    int random_start;

    push_text("\\u00eF", 1'b0);        // full escape, lower high digit
    push_text("\\u007F", 1'b0);        // high digit below 8
    push_text("\\u00A\\", 1'b1);       // low digit is a backslash, then chunk flush
    push_text("\\u0\\u", 1'b1);        // mismatch on second zero, flush of partial
    push_text("\\uz", 1'b0);           // mismatch after u
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);

    random_start = text_q.size();
    while (text_q.size() - random_start < RANDOM_BYTES) begin
      kind = $urandom_range(9);
      esc = '{CH_BSLASH, CH_U, CH_ZERO, CH_ZERO,
              hex_char($urandom_range(8, 15), $urandom_range(1)),
              hex_char($urandom_range(15), $urandom_range(1))};
      if (kind < 6) begin
        foreach (esc[i]) push_byte(esc[i], $urandom_range(15) == 0);
      end else if (kind < 8) begin
        // broken escape: a prefix, then an arbitrary byte
        cut = $urandom_range(1, 5);
        for (int i = 0; i < cut; i++) push_byte(esc[i], $urandom_range(15) == 0);
        push_byte($urandom_range(1) ? CH_BSLASH : 8'($urandom_range(255)),
                  $urandom_range(9) == 0);
      end else begin
        repeat ($urandom_range(1, 4))
          push_byte($urandom_range(3) == 0 ? CH_BSLASH : 8'($urandom_range(255)),
                    $urandom_range(9) == 0);
      end
    end
    push_byte("Z", 1'b1);              // flush anything still held
    text_total = text_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_taken != text_total) @(negedge clk);
    while (utf8_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (!mismatch_seen)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
